### sv/aes128_pkg.sv
// Shared types, constants and byte-level functions for the AES-128 encryption pipeline.
// Depends on nothing; every other file refers to it by scoped names.

package aes128_pkg;

	localparam int ROUNDS = 10;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
	} plain_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} cipher_t;

	typedef logic [127:0] block_t;

	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW  = 2'd1;

	localparam logic [7:0] GF_POLY = 8'h1b;

	localparam logic [2047:0] SBOX_TAB = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return SBOX_TAB[{~b, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
	endfunction

	// Round constant for round r of the key schedule, evaluated at elaboration.
	function automatic logic [7:0] rcon(input int r);
		logic [7:0] v;
		v = 8'h01;
		for (int i = 1; i < r; i++) begin
			v = xtime(v);
		end
		return v;
	endfunction

	function automatic logic [7:0] get_byte(input block_t x, input int i);
		return x[8 * (15 - i) +: 8];
	endfunction

	function automatic block_t sub_shift(input block_t s);
		block_t t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int row = 0; row < 4; row++) begin
				t[8 * (15 - (4 * c + row)) +: 8] =
					sbox(get_byte(s, 4 * ((c + row) % 4) + row));
			end
		end
		return t;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4 * c);
			a1 = get_byte(s, 4 * c + 1);
			a2 = get_byte(s, 4 * c + 2);
			a3 = get_byte(s, 4 * c + 3);
			t[8 * (15 - 4 * c) +: 8]       = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			t[8 * (15 - 4 * c - 1) +: 8]   = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			t[8 * (15 - 4 * c - 2) +: 8]   = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			t[8 * (15 - 4 * c - 3) +: 8]   = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return t;
	endfunction

endpackage

### sv/aes128_round.sv
// One cipher round together with the matching step of the key schedule.
// Depends on aes128_pkg for the S-box, ShiftRows and MixColumns functions.

module aes128_round #(
	parameter logic       LAST = 1'b0,
	parameter logic [7:0] RCON = 8'h01
) (
	input  aes128_pkg::block_t st,
	input  aes128_pkg::block_t rk,
	output aes128_pkg::block_t st_nxt,
	output aes128_pkg::block_t rk_nxt
);

	logic [31:0]        tw;
	logic [31:0]        w0, w1, w2, w3;
	aes128_pkg::block_t ss;

	always_comb begin
		tw = {aes128_pkg::sbox(rk[23:16]) ^ RCON, aes128_pkg::sbox(rk[15:8]),
			aes128_pkg::sbox(rk[7:0]), aes128_pkg::sbox(rk[31:24])};
		w0 = tw ^ rk[127:96];
		w1 = w0 ^ rk[95:64];
		w2 = w1 ^ rk[63:32];
		w3 = w2 ^ rk[31:0];
		rk_nxt = {w0, w1, w2, w3};
	end

	always_comb begin
		ss = aes128_pkg::sub_shift(st);
		if (LAST) begin
			st_nxt = ss ^ rk_nxt;
		end else begin
			st_nxt = aes128_pkg::mix_columns(ss) ^ rk_nxt;
		end
	end

endmodule

### sv/aes128_block_encrypt.sv
// Top level of the pipelined AES-128 encryption engine: key registers and the round pipeline.
// Depends on aes128_pkg and instantiates aes128_round once per round.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------
//  plain    | plain_valid, plain_stall   | plain  (plain_high, plain_low)
//  cipher   | cipher_valid, cipher_stall | cipher (cipher_high, cipher_low)
//  cfg      | cfg_we                     | cfg_index, cfg_data (key registers)
//
// One block is accepted every cycle while plain_stall is low; there is one register stage for the
// initial key addition and one stage for each round, with the round key carried alongside.
// Reset clears the key registers and all stage valid bits; data registers are not reset.
// Each stage holds its request only while the stage after it is full and stalled, so bubbles
// close up and plain_stall rises only when every stage holds a request.

module aes128_block_encrypt #(
	parameter int ROUNDS = aes128_pkg::ROUNDS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                plain_valid,
	output logic                plain_stall,
	input  aes128_pkg::plain_t  plain,
	output logic                cipher_valid,
	input  logic                cipher_stall,
	output aes128_pkg::cipher_t cipher,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data
);

	logic [63:0]        key_high_q;
	logic [63:0]        key_low_q;
	logic [ROUNDS:0]    vld_s;
	logic [ROUNDS:0]    adv;
	aes128_pkg::block_t st_s [ROUNDS + 1];
	aes128_pkg::block_t rk_s [ROUNDS + 1];
	aes128_pkg::block_t st_nxt [ROUNDS + 1];
	aes128_pkg::block_t rk_nxt [ROUNDS + 1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				aes128_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				aes128_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		adv[ROUNDS] = !vld_s[ROUNDS] || !cipher_stall;
		for (int i = ROUNDS - 1; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i + 1];
		end
	end

	assign st_nxt[0] = {plain.plain_high, plain.plain_low} ^ {key_high_q, key_low_q};
	assign rk_nxt[0] = {key_high_q, key_low_q};

	for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
		aes128_round #(
			.LAST (r == ROUNDS),
			.RCON (aes128_pkg::rcon(r))
		) u_round (
			.st     (st_s[r - 1]),
			.rk     (rk_s[r - 1]),
			.st_nxt (st_nxt[r]),
			.rk_nxt (rk_nxt[r])
		);
	end

	for (genvar i = 0; i <= ROUNDS; i++) begin : g_stage
		logic in_vld;
		if (i == 0) begin : g_first
			assign in_vld = plain_valid;
		end else begin : g_next
			assign in_vld = vld_s[i - 1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv[i]) begin
				vld_s[i] <= in_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[i] && in_vld) begin
				st_s[i] <= st_nxt[i];
				rk_s[i] <= rk_nxt[i];
			end
		end
	end

	assign plain_stall  = !adv[0];
	assign cipher_valid = vld_s[ROUNDS];
	assign cipher       = aes128_pkg::cipher_t'(st_s[ROUNDS]);

	a_stall_full : assert property (@(posedge clk) disable iff (!arst_n)
		plain_stall |-> (&vld_s))
		else $error("Input is stalled while a pipeline stage is empty.");

	a_hold_kept : assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((vld_s & $past(vld_s & ~adv)) == $past(vld_s & ~adv)))
		else $error("A held pipeline stage lost its request.");

	a_enter : assert property (@(posedge clk) disable iff (!arst_n)
		(plain_valid && !plain_stall) |=> vld_s[0])
		else $error("An accepted request did not reach the first stage.");

	a_out_move : assert property (@(posedge clk) disable iff (!arst_n)
		(!vld_s[ROUNDS] && vld_s[ROUNDS - 1]) |=> vld_s[ROUNDS])
		else $error("A finished round did not move into the output stage.");

endmodule
